/* rtl/bdq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_REAR = 3'd0,
        MODE_POP_FRONT = 3'd1,
        MODE_POP_REAR  = 3'd2,
        MODE_DELETE    = 3'd3,
        MODE_CLEAR     = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_ZERO     = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_DFRONT,
        S_DREAR,
        S_DMID,
        S_SHIFT
    } t_state;

    // Physical slot of the entry at a given distance from the head.
    function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] offset);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(offset);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/bdq_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bdq_in_if;
    logic                        valid;
    logic                        ready;
    logic [bdq_pkg::MODE_W-1:0]  mode;
    logic [bdq_pkg::VALUE_W-1:0] value;

    modport source (output valid, mode, value, input ready);
    modport sink   (input valid, mode, value, output ready);
endinterface

interface bdq_out_if;
    logic                         valid;
    logic                         ready;
    logic [bdq_pkg::STATUS_W-1:0] status;
    logic [bdq_pkg::VALUE_W-1:0]  popped_value;
    logic [bdq_pkg::CNT_W-1:0]    count;

    modport source (output valid, status, popped_value, count, input ready);
    modport sink   (input valid, status, popped_value, count, output ready);
endinterface

`default_nettype wire

/* rtl/bdq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module bdq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/bounded_deque_with_delete.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of up to DEPTH nonzero 32-bit values held in a
// circular single-port-write, single-port-read memory with a registered read
// port. One result item is returned for every input item. A push, a clear,
// an unused mode and every refused operation give their result in the cycle
// after acceptance; a pop first reads the memory and then registers the
// result. A delete reads and compares the front entry, and if that misses
// reads and compares the rear entry; a middle delete then walks the entries
// after the front one per cycle and then moves each later entry one place
// forward, one per cycle. The walk and the moves together pass over the held
// entries once. The single memory read port sets this order of steps. The
// block works on one item at a time: a new item is taken only when the
// sequencer is idle and the output register is empty or being emptied in the
// same cycle.
module bounded_deque_with_delete (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bdq_in_if.sink     i_in,
    bdq_out_if.source  o_out
);

    localparam int IDX_W   = bdq_pkg::IDX_W;
    localparam int CNT_W   = bdq_pkg::CNT_W;
    localparam int VALUE_W = bdq_pkg::VALUE_W;

    // Sequencer and deque bookkeeping.
    bdq_pkg::t_state     r_state, n_state;
    logic [IDX_W-1:0]    r_head,  n_head;
    logic [CNT_W-1:0]    r_cnt,   n_cnt;
    logic [CNT_W-1:0]    r_idx,   n_idx;
    logic [VALUE_W-1:0]  r_val,   n_val;
    logic                r_front, n_front;

    // Output register.
    logic                 r_ovalid;
    bdq_pkg::t_status     r_ostatus;
    logic [VALUE_W-1:0]   r_opopped;
    logic [CNT_W-1:0]     r_ocount;

    // Result produced this cycle.
    logic                 res_load;
    bdq_pkg::t_status     res_status;
    logic [VALUE_W-1:0]   res_popped;

    // Memory port signals.
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [VALUE_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [VALUE_W-1:0]   ram_rdata;

    logic                 accept;
    logic                 hit;
    logic [CNT_W:0]       idx_plus2;

    bdq_ram #(
        .DEPTH (bdq_pkg::DEPTH),
        .WIDTH (VALUE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // An item is taken only when idle, and only if the output register will
    // be free at the next edge, so a result never has to wait for space.
    assign i_in.ready = (r_state == bdq_pkg::S_IDLE) && (!r_ovalid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    // The entry read in the previous cycle is compared with the value held
    // for a delete.
    assign hit       = (ram_rdata == r_val);
    assign idx_plus2 = (CNT_W + 1)'(r_idx) + (CNT_W + 1)'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdq_pkg::S_IDLE;
            r_head  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_val   <= n_val;
        r_front <= n_front;
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_idx      = r_idx;
        n_val      = r_val;
        n_front    = r_front;
        res_load   = 1'b0;
        res_status = bdq_pkg::ST_DONE;
        res_popped = '0;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = r_val;
        ram_raddr  = '0;

        case (r_state)
            bdq_pkg::S_IDLE: begin
                if (accept) begin
                    n_val = i_in.value;
                    case (i_in.mode)
                        bdq_pkg::MODE_PUSH_REAR: begin
                            res_load = 1'b1;
                            if (i_in.value == '0) begin
                                res_status = bdq_pkg::ST_ZERO;
                            end else if (r_cnt == CNT_W'(bdq_pkg::DEPTH)) begin
                                res_status = bdq_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = bdq_pkg::slot(r_head, r_cnt);
                                ram_wdata = i_in.value;
                                n_cnt     = r_cnt + CNT_W'(1);
                            end
                        end
                        bdq_pkg::MODE_POP_FRONT, bdq_pkg::MODE_POP_REAR: begin
                            if (r_cnt == '0) begin
                                res_load   = 1'b1;
                                res_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_front = (i_in.mode == bdq_pkg::MODE_POP_FRONT);
                                if (i_in.mode == bdq_pkg::MODE_POP_FRONT) begin
                                    ram_raddr = r_head;
                                end else begin
                                    ram_raddr = bdq_pkg::slot(r_head, r_cnt - CNT_W'(1));
                                end
                                n_state = bdq_pkg::S_POP;
                            end
                        end
                        bdq_pkg::MODE_DELETE: begin
                            if (i_in.value == '0) begin
                                res_load   = 1'b1;
                                res_status = bdq_pkg::ST_ZERO;
                            end else if (r_cnt == '0) begin
                                res_load   = 1'b1;
                                res_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                ram_raddr = r_head;
                                n_state   = bdq_pkg::S_DFRONT;
                            end
                        end
                        bdq_pkg::MODE_CLEAR: begin
                            res_load = 1'b1;
                            n_cnt    = '0;
                            n_head   = '0;
                        end
                        default: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end

            // Read data is the entry being popped.
            bdq_pkg::S_POP: begin
                res_load   = 1'b1;
                res_popped = ram_rdata;
                n_cnt      = r_cnt - CNT_W'(1);
                if (r_front) begin
                    n_head = bdq_pkg::slot(r_head, CNT_W'(1));
                end
                n_state = bdq_pkg::S_IDLE;
            end

            // Read data is the front entry.
            bdq_pkg::S_DFRONT: begin
                if (hit) begin
                    res_load = 1'b1;
                    n_head   = bdq_pkg::slot(r_head, CNT_W'(1));
                    n_cnt    = r_cnt - CNT_W'(1);
                    n_state  = bdq_pkg::S_IDLE;
                end else begin
                    ram_raddr = bdq_pkg::slot(r_head, r_cnt - CNT_W'(1));
                    n_state   = bdq_pkg::S_DREAR;
                end
            end

            // Read data is the rear entry.
            bdq_pkg::S_DREAR: begin
                n_idx = CNT_W'(1);
                if (hit) begin
                    res_load = 1'b1;
                    n_cnt    = r_cnt - CNT_W'(1);
                    n_state  = bdq_pkg::S_IDLE;
                end else if ((CNT_W + 1)'(2) < (CNT_W + 1)'(r_cnt)) begin
                    ram_raddr = bdq_pkg::slot(r_head, CNT_W'(1));
                    n_state   = bdq_pkg::S_DMID;
                end else begin
                    res_load   = 1'b1;
                    res_status = bdq_pkg::ST_NOTFOUND;
                    n_state    = bdq_pkg::S_IDLE;
                end
            end

            // Read data is the middle entry at distance r_idx from the head.
            bdq_pkg::S_DMID: begin
                if (hit) begin
                    // Start closing the gap: fetch the entry behind it.
                    ram_raddr = bdq_pkg::slot(r_head, r_idx + CNT_W'(1));
                    n_state   = bdq_pkg::S_SHIFT;
                end else if (idx_plus2 < (CNT_W + 1)'(r_cnt)) begin
                    n_idx     = r_idx + CNT_W'(1);
                    ram_raddr = bdq_pkg::slot(r_head, r_idx + CNT_W'(1));
                end else begin
                    res_load   = 1'b1;
                    res_status = bdq_pkg::ST_NOTFOUND;
                    n_state    = bdq_pkg::S_IDLE;
                end
            end

            // Read data is the entry at r_idx + 1; it moves down to r_idx while
            // the next one is fetched, so the two addresses always differ.
            bdq_pkg::S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = bdq_pkg::slot(r_head, r_idx);
                ram_wdata = ram_rdata;
                n_idx     = r_idx + CNT_W'(1);
                if (idx_plus2 < (CNT_W + 1)'(r_cnt)) begin
                    ram_raddr = bdq_pkg::slot(r_head, idx_plus2[CNT_W-1:0]);
                end else begin
                    res_load = 1'b1;
                    n_cnt    = r_cnt - CNT_W'(1);
                    n_state  = bdq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bdq_pkg::S_IDLE;
            end
        endcase
    end

    // Output register: loaded with a finished result, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_load) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_ostatus <= res_status;
            r_opopped <= res_popped;
            r_ocount  <= n_cnt;
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_ostatus;
    assign o_out.popped_value = r_opopped;
    assign o_out.count        = r_ocount;

    // A result must never overwrite one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_load |-> (!r_ovalid || o_out.ready))
        else $error("result loaded over an untaken result");

    // The fill level never exceeds the capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(bdq_pkg::DEPTH))
        else $error("entry count above capacity");

    // A refused or unsuccessful operation leaves the fill level alone.
    a_fail_keeps_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_load && res_status != bdq_pkg::ST_DONE) |=> (r_cnt == $past(r_cnt)))
        else $error("failed operation changed the entry count");

    // While shifting, the write and the read never target the same slot.
    a_shift_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bdq_pkg::S_SHIFT && !res_load) |-> (ram_raddr != ram_waddr))
        else $error("shift read and write collide");

endmodule

`default_nettype wire
